FILE: hdl/qdtf_pkg.sv
// Shared constants, codes and types of the quad depth-test framebuffer.
package qdtf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int LANES  = 4;
  localparam int LANE_W = 2;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int BANK_DEPTH = (STORE_SIZE + LANES - 1) / LANES;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ADDR_W     = BANK_AW + LANE_W;

  localparam int DEPTH_W   = 24;
  localparam int COLOUR_W  = 24;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int COL_W     = 9;
  localparam int MULT_W    = COORD_W + DIM_W + 1;
  localparam int ACTION_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE   = 24'h800000;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd256;

  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TEST       = 3'd0,
    ACT_WR_DEPTH   = 3'd1,
    ACT_WR_COLOUR  = 3'd2,
    ACT_CLR_COLOUR = 3'd3,
    ACT_CLR_DEPTH  = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_index_e;

  // One bank's access: read and write enables, row index, depth and colour.
  typedef struct packed {
    logic                rd_en;
    logic                dep_we;
    logic                col_we;
    logic [BANK_AW-1:0]  idx;
    logic [DEPTH_W-1:0]  depth;
    logic [COLOUR_W-1:0] colour;
  } bank_req_t;

  // Item whose bank reads are in flight, seen by the merge stage.
  typedef struct packed {
    logic              valid;
    logic              test;
    logic [LANE_W-1:0] lo;
    logic [LANES-1:0]  in_frame;
  } slot_t;

endpackage

FILE: hdl/qdtf_ram.sv
// Generic single-port RAM with registered read.
module qdtf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/qdtf_bank.sv
// One lane bank: depth and colour RAMs for a quarter of the frame, and the depth compare.
module qdtf_bank
  import qdtf_pkg::*;
(
  input  logic      clk_i,
  input  bank_req_t req_i,
  output logic      pass_o
);

  logic [DEPTH_W-1:0] depth_in_q;
  logic [DEPTH_W-1:0] depth_rd;

  qdtf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .en_i    (req_i.rd_en | req_i.dep_we),
    .we_i    (req_i.dep_we),
    .addr_i  (req_i.idx),
    .wdata_i (req_i.depth),
    .rdata_o (depth_rd)
  );

  // colour is never read back through the ports
  qdtf_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_colour_ram (
    .clk_i   (clk_i),
    .en_i    (req_i.col_we),
    .we_i    (req_i.col_we),
    .addr_i  (req_i.idx),
    .wdata_i (req_i.colour),
    .rdata_o ()
  );

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      depth_in_q <= req_i.depth;
    end
  end

  assign pass_o = depth_in_q < depth_rd;

endmodule

FILE: hdl/qdtf_merge.sv
// Merge stage: puts bank results back in lane order and queues the pass masks.
module qdtf_merge
  import qdtf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_t            slot_i,
  input  logic [LANES-1:0] bank_pass_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [LANES-1:0] pass_mask_o,
  output logic             room_o
);

  logic [LANES-1:0]     mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [LANES-1:0]     lane_pass;
  logic                 pop;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_pass[i] = slot_i.test && slot_i.in_frame[i] &&
                     bank_pass_i[LANE_W'(slot_i.lo + LANE_W'(i))];
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign pass_mask_o = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // a word in flight already holds its place
  assign room_o      = ((cnt_q + RES_CNT_W'(slot_i.valid)) < RES_CNT_W'(RES_DEPTH)) || pop;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (slot_i.valid) begin
      wr_ptr_d = (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + RES_CNT_W'(slot_i.valid) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_i.valid) begin
      mem_q[wr_ptr_q] <= lane_pass;
    end
  end

endmodule

FILE: hdl/quad_depth_test_framebuffer.sv
// Top level of the quad depth-test framebuffer: address mapping, clearing sweep, lane banks.
//
// Each input word names four adjacent pixels on one row and carries one action: a less-than
// depth test, a masked depth or colour write, or a clear of the colour or depth store. The
// stores are split into four banks by the low two address bits, so the four consecutive
// pixels of a word always fall in distinct banks and each bank's single RAM port serves one
// lane: one word is taken per cycle while in_ready_o is high, and its pass mask is formed
// by the registered RAM read, compare and queue, with a two-word result queue so input keeps
// flowing while a result waits. Every word, clears and unused codes included, gives one
// result word; only a depth test can give a non-zero mask. A clear walks every bank row,
// BANK_DEPTH rows (16384 at the default 256 x 256 frame), during which in_ready_o is low;
// the same sweep clears both stores after reset. Configuration writes are always taken
// (cfg_ready_o stays high) and only change the address mapping; the stores keep their contents.
module quad_depth_test_framebuffer
  import qdtf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [COORD_W-1:0]   x_base_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [LANES-1:0]     lane_mask_i,
  input  logic [DEPTH_W-1:0]   depth_lane0_i,
  input  logic [DEPTH_W-1:0]   depth_lane1_i,
  input  logic [DEPTH_W-1:0]   depth_lane2_i,
  input  logic [DEPTH_W-1:0]   depth_lane3_i,
  input  logic [COLOUR_W-1:0]  color_lane0_i,
  input  logic [COLOUR_W-1:0]  color_lane1_i,
  input  logic [COLOUR_W-1:0]  color_lane2_i,
  input  logic [COLOUR_W-1:0]  color_lane3_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LANES-1:0]     pass_mask_o
);

  // configuration
  logic [DIM_W-1:0] frame_width_q;
  logic [DIM_W-1:0] frame_height_q;

  // clearing sweep
  logic               sweep_q;
  logic               sweep_col_q;
  logic               sweep_dep_q;
  logic [BANK_AW-1:0] sweep_idx_q;

  logic [DIM_W-1:0]    w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic [MULT_W-1:0]   base_full;
  logic [COL_W-1:0]    col      [LANES];
  logic [ADDR_W-1:0]   lane_addr[LANES];
  logic [LANES-1:0]    in_frame;
  logic [DEPTH_W-1:0]  depth_in [LANES];
  logic [COLOUR_W-1:0] colour_in[LANES];

  bank_req_t        bank_req [LANES];
  logic [LANES-1:0] bank_pass;
  slot_t            slot_q;
  logic             room;
  logic             in_acc;
  logic             is_clear;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !sweep_q && room;
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_clear    = (action_i == ACT_CLR_COLOUR) || (action_i == ACT_CLR_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_RESET;
      frame_height_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame size limited to the store's geometry
  assign w_eff = (frame_width_q  > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : frame_width_q;
  assign h_eff = (frame_height_q > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height_q;

  assign base_full = MULT_W'(row_i) * MULT_W'(w_eff) + MULT_W'(x_base_i);

  assign depth_in[0]  = depth_lane0_i;
  assign depth_in[1]  = depth_lane1_i;
  assign depth_in[2]  = depth_lane2_i;
  assign depth_in[3]  = depth_lane3_i;
  assign colour_in[0] = color_lane0_i;
  assign colour_in[1] = color_lane1_i;
  assign colour_in[2] = color_lane2_i;
  assign colour_in[3] = color_lane3_i;

  // lanes outside the frame are dropped; an in-frame address is always inside the store
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      col[i]       = COL_W'(x_base_i) + COL_W'(i);
      in_frame[i]  = (col[i] < w_eff) && (DIM_W'(row_i) < h_eff);
      lane_addr[i] = ADDR_W'(base_full + MULT_W'(i));
    end
  end

  // bank b serves the lane whose address ends in b; the sweep takes over every bank
  always_comb begin
    logic [LANE_W-1:0] l;
    for (int b = 0; b < LANES; b++) begin
      l = LANE_W'(b) - base_full[LANE_W-1:0];
      if (sweep_q) begin
        bank_req[b].rd_en  = 1'b0;
        bank_req[b].dep_we = sweep_dep_q;
        bank_req[b].col_we = sweep_col_q;
        bank_req[b].idx    = sweep_idx_q;
        bank_req[b].depth  = DEPTH_ONE;
        bank_req[b].colour = '0;
      end else begin
        bank_req[b].rd_en  = in_acc && (action_i == ACT_TEST);
        bank_req[b].dep_we = in_acc && (action_i == ACT_WR_DEPTH) &&
                             lane_mask_i[l] && in_frame[l];
        bank_req[b].col_we = in_acc && (action_i == ACT_WR_COLOUR) &&
                             lane_mask_i[l] && in_frame[l];
        bank_req[b].idx    = lane_addr[l][ADDR_W-1:LANE_W];
        bank_req[b].depth  = depth_in[l];
        bank_req[b].colour = colour_in[l];
      end
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    qdtf_bank u_bank (
      .clk_i  (clk_i),
      .req_i  (bank_req[b]),
      .pass_o (bank_pass[b])
    );
  end

  // sweep: starts at reset and on a clear word, one bank row a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_col_q <= 1'b1;
      sweep_dep_q <= 1'b1;
      sweep_idx_q <= '0;
    end else if (sweep_q) begin
      if (sweep_idx_q == BANK_AW'(BANK_DEPTH - 1)) begin
        sweep_q <= 1'b0;
      end else begin
        sweep_idx_q <= sweep_idx_q + 1'b1;
      end
    end else if (in_acc && is_clear) begin
      sweep_q     <= 1'b1;
      sweep_col_q <= action_i == ACT_CLR_COLOUR;
      sweep_dep_q <= action_i == ACT_CLR_DEPTH;
      sweep_idx_q <= '0;
    end
  end

  // word in flight while the bank reads complete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q.valid <= in_acc;
      if (in_acc) begin
        slot_q.test     <= action_i == ACT_TEST;
        slot_q.lo       <= base_full[LANE_W-1:0];
        slot_q.in_frame <= in_frame;
      end
    end
  end

  qdtf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_i      (slot_q),
    .bank_pass_i (bank_pass),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .pass_mask_o (pass_mask_o),
    .room_o      (room)
  );

endmodule

FILE: hdl/qdtf_checker.sv
// Port-level checks of the quad depth-test framebuffer, bound to the top level.
module qdtf_checker
  import qdtf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [ACTION_W-1:0]  action_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [LANES-1:0]     pass_mask_o
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pass_mask_o))
    else $error("result word changed while stalled");

  // an empty result queue only fills from an accepted word that has passed the in-flight slot
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result word without an accepted input word");

  // a clear word starts the sweep, which blocks input
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    ((action_i == ACT_CLR_COLOUR) || (action_i == ACT_CLR_DEPTH)) |=> !in_ready_o)
    else $error("input taken during a clear");

  // the store clear after reset blocks input
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input taken before the reset clear");

endmodule

bind quad_depth_test_framebuffer qdtf_checker u_checker (.*);

FILE: bench/qdtf_mask_checker.sv
// Pass-mask predictor and result comparison for the quad depth-test framebuffer bench.
module qdtf_mask_checker
  import qdtf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [COORD_W-1:0]   x_base_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [LANES-1:0]     lane_mask_i,
  input  logic [DEPTH_W-1:0]   depth_lane0_i,
  input  logic [DEPTH_W-1:0]   depth_lane1_i,
  input  logic [DEPTH_W-1:0]   depth_lane2_i,
  input  logic [DEPTH_W-1:0]   depth_lane3_i,
  input  logic [COLOUR_W-1:0]  color_lane0_i,
  input  logic [COLOUR_W-1:0]  color_lane1_i,
  input  logic [COLOUR_W-1:0]  color_lane2_i,
  input  logic [COLOUR_W-1:0]  color_lane3_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [LANES-1:0]     pass_mask_i,

  output int                   mismatch_count_o,
  output int                   masks_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [LANES-1:0][DEPTH_W-1:0]  quad_depth_t;
  typedef logic [LANES-1:0][COLOUR_W-1:0] quad_colour_t;

  // Own copy of the frame stores and frame size
  logic [DEPTH_W-1:0]  depth_mem  [STORE_SIZE];
  logic [COLOUR_W-1:0] colour_mem [STORE_SIZE];
  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;

  logic [LANES-1:0]    masks_due [$];
  int                  mismatches;
  int                  results_seen;

  initial begin
    mismatch_count_o = 0;
    masks_due_o      = 0;
    mismatches       = 0;
    results_seen     = 0;
  end

  function automatic void fill_depth();
    for (int a = 0; a < STORE_SIZE; a++) depth_mem[a] = DEPTH_ONE;
  endfunction

  function automatic void fill_colour();
    for (int a = 0; a < STORE_SIZE; a++) colour_mem[a] = '0;
  endfunction

  // Whether one lane falls inside the frame in use, with its address (0 when it does not)
  function automatic bit lane_addr(input int lane, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] r, output int addr);
    int w;
    int h;
    int col;
    w    = (int'(width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    h    = (int'(height_q) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
    col  = int'(x) + lane;
    addr = 0;
    if (col >= w || int'(r) >= h) return 1'b0;
    addr = int'(r) * w + col;
    return addr < STORE_SIZE;
  endfunction

  // Applies one word to the stores and gives the mask it should return
  function automatic logic [LANES-1:0] depth_test_quad(
      input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] r, input logic [LANES-1:0] m,
      input quad_depth_t deps, input quad_colour_t cols);
    logic [LANES-1:0] pass;
    bit               hit;
    int               addr;
    pass = '0;
    case (act)
      ACT_TEST: begin
        for (int i = 0; i < LANES; i++) begin
          hit = lane_addr(i, x, r, addr);
          if (hit && deps[i] < depth_mem[addr]) pass[i] = 1'b1;
        end
      end
      ACT_WR_DEPTH: begin
        for (int i = 0; i < LANES; i++) begin
          hit = lane_addr(i, x, r, addr);
          if (m[i] && hit) depth_mem[addr] = deps[i];
        end
      end
      ACT_WR_COLOUR: begin
        for (int i = 0; i < LANES; i++) begin
          hit = lane_addr(i, x, r, addr);
          if (m[i] && hit) colour_mem[addr] = cols[i];
        end
      end
      ACT_CLR_COLOUR: fill_colour();
      ACT_CLR_DEPTH:  fill_depth();
      default: ;
    endcase
    return pass;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 10) $display("%0t mask mismatch, result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : watch
    logic [LANES-1:0] want;
    if (!rst_ni) begin
      width_q  = DIM_RESET;
      height_q = DIM_RESET;
      fill_depth();
      fill_colour();
      masks_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  width_q  = cfg_data_i;
          CFG_FRAME_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        masks_due.push_back(depth_test_quad(action_i, x_base_i, row_i, lane_mask_i,
            {depth_lane3_i, depth_lane2_i, depth_lane1_i, depth_lane0_i},
            {color_lane3_i, color_lane2_i, color_lane1_i, color_lane0_i}));
      end
      if (out_valid_i && out_ready_i) begin
        if (masks_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word, pass_mask %b", pass_mask_i));
        end else begin
          want = masks_due.pop_front();
          if (pass_mask_i !== want)
            note_mismatch($sformatf("expected %b got %b", want, pass_mask_i));
        end
        results_seen++;
      end
    end
    mismatch_count_o <= mismatches;
    masks_due_o      <= masks_due.size();
  end

endmodule

FILE: bench/quad_depth_test_framebuffer_tb.sv
// Stimulus, clock, reset and verdict for the quad depth-test framebuffer bench.
module quad_depth_test_framebuffer_tb
  import qdtf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [LANES-1:0][DEPTH_W-1:0]  quad_depth_t;
  typedef logic [LANES-1:0][COLOUR_W-1:0] quad_colour_t;

  // Action codes the block must ignore (not in the package enum)
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [DEPTH_W-1:0]  DEPTH_HALF   = DEPTH_ONE >> 1;
  localparam int                  ITEMS_PER_PHASE = 125;
  localparam int                  PHASES          = 8;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  action    = ACT_TEST;
  logic [COORD_W-1:0]   x_base    = '0;
  logic [COORD_W-1:0]   row       = '0;
  logic [LANES-1:0]     lane_mask = '0;
  logic [DEPTH_W-1:0]   depth_lane0 = '0;
  logic [DEPTH_W-1:0]   depth_lane1 = '0;
  logic [DEPTH_W-1:0]   depth_lane2 = '0;
  logic [DEPTH_W-1:0]   depth_lane3 = '0;
  logic [COLOUR_W-1:0]  color_lane0 = '0;
  logic [COLOUR_W-1:0]  color_lane1 = '0;
  logic [COLOUR_W-1:0]  color_lane2 = '0;
  logic [COLOUR_W-1:0]  color_lane3 = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [LANES-1:0]     pass_mask;

  int                   mismatch_count;
  int                   masks_due;

  // Idling knobs, percent per cycle; changed per phase
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;

  // Frame size currently programmed, steers where random words land
  int                   cur_w = 256;
  int                   cur_h = 256;
  int                   clears_left = 8;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  quad_depth_test_framebuffer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .x_base_i      (x_base),
    .row_i         (row),
    .lane_mask_i   (lane_mask),
    .depth_lane0_i (depth_lane0),
    .depth_lane1_i (depth_lane1),
    .depth_lane2_i (depth_lane2),
    .depth_lane3_i (depth_lane3),
    .color_lane0_i (color_lane0),
    .color_lane1_i (color_lane1),
    .color_lane2_i (color_lane2),
    .color_lane3_i (color_lane3),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pass_mask_o   (pass_mask)
  );

  qdtf_mask_checker u_mask_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .x_base_i         (x_base),
    .row_i            (row),
    .lane_mask_i      (lane_mask),
    .depth_lane0_i    (depth_lane0),
    .depth_lane1_i    (depth_lane1),
    .depth_lane2_i    (depth_lane2),
    .depth_lane3_i    (depth_lane3),
    .color_lane0_i    (color_lane0),
    .color_lane1_i    (color_lane1),
    .color_lane2_i    (color_lane2),
    .color_lane3_i    (color_lane3),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pass_mask_i      (pass_mask),
    .mismatch_count_o (mismatch_count),
    .masks_due_o      (masks_due)
  );

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Presents one word and returns at the edge that takes it. Valid is never dropped here
  // except in a sender gap, so back-to-back words keep valid high across the edge.
  task automatic put_word(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] r, input logic [LANES-1:0] m,
                          input quad_depth_t deps, input quad_colour_t cols);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    x_base      <= x;
    row         <= r;
    lane_mask   <= m;
    depth_lane0 <= deps[0];
    depth_lane1 <= deps[1];
    depth_lane2 <= deps[2];
    depth_lane3 <= deps[3];
    color_lane0 <= cols[0];
    color_lane1 <= cols[1];
    color_lane2 <= cols[2];
    color_lane3 <= cols[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Depths lean towards the ends of the range and a tight cluster mid-range, so that
  // equal codes (strict compare must fail) turn up often.
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int c;
    c = $urandom_range(0, 9);
    if (c == 0) return '0;
    if (c == 1) return DEPTH_ONE;
    if (c < 5)  return DEPTH_HALF + DEPTH_W'($urandom_range(0, 3));
    return DEPTH_W'($urandom_range(0, DEPTH_ONE));
  endfunction

  task automatic put_random_word();
    logic [ACTION_W-1:0] act;
    quad_depth_t         deps;
    quad_colour_t        cols;
    int                  pick;
    int                  cls;
    int                  x;
    int                  r;
    pick = $urandom_range(0, 999);
    if (clears_left > 0 && pick < 5) begin
      act = $urandom_range(0, 1) ? ACT_CLR_COLOUR : ACT_CLR_DEPTH;
      clears_left--;
    end else if (pick < 30) begin
      act = ACT_SPARE_LO + ACTION_W'($urandom_range(0, 2));
    end else if (pick < 450) begin
      act = ACT_TEST;
    end else if (pick < 800) begin
      act = ACT_WR_DEPTH;
    end else begin
      act = ACT_WR_COLOUR;
    end
    cls = $urandom_range(0, 99);
    if (cls < 75) begin
      // small hot patch at the frame origin: writes and tests keep hitting each other
      x = $urandom_range(0, (cur_w < 16 ? cur_w : 16) - 1);
      r = $urandom_range(0, (cur_h < 4 ? cur_h : 4) - 1);
    end else if (cls < 90) begin
      // right-hand edge, last row or rows past the bottom
      x = $urandom_range(cur_w - 4, 255);
      if ($urandom_range(0, 1) || cur_h > 255) r = cur_h - 1;
      else r = $urandom_range(cur_h, 255);
    end else begin
      x = $urandom_range(0, 255);
      r = $urandom_range(0, 255);
    end
    for (int i = 0; i < LANES; i++) begin
      deps[i] = pick_depth();
      cols[i] = COLOUR_W'($urandom());
    end
    put_word(act, x[COORD_W-1:0], r[COORD_W-1:0], LANES'($urandom_range(0, 15)), deps, cols);
  endtask

  // Waits until every outstanding mask has come back, plus a little pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (masks_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Frame size changes only with the block idle; a clear sweep may still hold in_ready low
  task automatic set_frame(input int w, input int h);
    drain();
    while (!in_ready) @(posedge clk);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  initial begin
    int w;
    int h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset frame of 256 x 256; depth lanes listed lane 3 first
    put_word(ACT_TEST, 8'd0, 8'd0, 4'h0,
             {24'h400000, 24'h800000, 24'h7FFFFF, 24'h000000}, '0);
    put_word(ACT_WR_DEPTH, 8'd0, 8'd0, 4'hF,
             {24'h800000, 24'h000000, 24'h400001, 24'h400000}, '0);
    // equal codes must fail the strict test
    put_word(ACT_TEST, 8'd0, 8'd0, 4'hF,
             {24'h7FFFFF, 24'h000000, 24'h400001, 24'h3FFFFF}, '0);
    put_word(ACT_WR_DEPTH, 8'd0, 8'd0, 4'h0, '0, '0);
    // test ignores the lane mask
    put_word(ACT_TEST, 8'd0, 8'd0, 4'h0,
             {24'h7FFFFF, 24'h000000, 24'h400000, 24'h3FFFFF}, '0);
    put_word(ACT_WR_DEPTH, 8'd1, 8'd0, 4'b0101,
             {24'h000001, 24'h000001, 24'h000001, 24'h000001}, '0);
    put_word(ACT_TEST, 8'd0, 8'd0, 4'hF,
             {24'h000001, 24'h000001, 24'h000001, 24'h000001}, '0);
    put_word(ACT_WR_COLOUR, 8'd0, 8'd0, 4'hF, '0,
             {24'h5A5A5A, 24'hA5A5A5, 24'h000000, 24'hFFFFFF});
    put_word(ACT_TEST, 8'd0, 8'd0, 4'hF,
             {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, '0);
    // lane 3 lands past the last column
    put_word(ACT_TEST, 8'd253, 8'd255, 4'hF, '0, '0);
    put_word(ACT_WR_DEPTH, 8'd255, 8'd255, 4'hF, '0, '0);
    put_word(ACT_TEST, 8'd255, 8'd255, 4'hF, '0, '0);
    // spare action codes, with fields at high, low and mixed values
    put_word(ACT_SPARE_LO, 8'hFF, 8'hFF, 4'hF,
             {4{DEPTH_ONE}}, {4{24'hFFFFFF}});
    put_word(ACT_SPARE_LO + 3'd1, 8'h00, 8'h00, 4'h0, '0, '0);
    put_word(ACT_SPARE_LO + 3'd2, 8'h5A, 8'hA5, 4'hA,
             {24'h123456, 24'h654321, 24'h0F0F0F, 24'h70F0F0}, {4{24'hC3C3C3}});
    // clears ignore every other field
    put_word(ACT_CLR_DEPTH, 8'hFF, 8'hFF, 4'hF, {4{DEPTH_ONE}}, {4{24'hFFFFFF}});
    put_word(ACT_TEST, 8'd0, 8'd0, 4'h0, {4{24'h7FFFFF}}, '0);
    put_word(ACT_TEST, 8'd255, 8'd255, 4'hF, {4{24'h7FFFFF}}, '0);
    put_word(ACT_CLR_COLOUR, 8'd0, 8'd0, 4'h0, '0, '0);
    put_word(ACT_WR_DEPTH, 8'hFF, 8'hFF, 4'hF, {4{DEPTH_ONE}}, {4{24'hFFFFFF}});
    put_word(ACT_TEST, 8'hFF, 8'hFF, 4'hF, {4{DEPTH_ONE}}, '0);
    put_word(ACT_TEST, 8'd0, 8'd0, 4'h0, '0, '0);

    // Random phases: frame extremes and random sizes, idling pattern rotates
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 256; h = 256; end
        1: begin w = 4;   h = 1;   end
        2: begin w = 256; h = 1;   end
        3: begin w = 4;   h = 256; end
        5: begin w = 17;  h = 200; end
        6: begin w = 256; h = 256; end
        default: begin
          w = $urandom_range(4, 256);
          h = $urandom_range(1, 256);
        end
      endcase
      set_frame(w, h);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (ITEMS_PER_PHASE) put_random_word();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && masks_due == 0) begin
      $display("quad_depth_test_framebuffer_tb: PASS");
    end else begin
      $display("quad_depth_test_framebuffer_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: roughly five times the slowest legal run (clear sweeps dominate)
  initial begin
    #(10_000_000);
    $display("quad_depth_test_framebuffer_tb: FAIL");
    $finish;
  end

endmodule
